// ----- sv/delv_pkg.sv -----
// ----------------------------------------------------------------------------
// delv_pkg
// Shared types and constants of the disk extent list validator: status codes,
// register indexes, the register set and the result item.
// ----------------------------------------------------------------------------
package delv_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_TOT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_CLUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVIE_CLUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVIE_BYTES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVIE_SECS   = 3'd5;

  // Largest byte size whose round-up to a whole sector still fits in 32 bits.
  localparam logic [31:0] MAX_BYTE_SIZE = 32'hFFFF_FE00;
  localparam logic [32:0] SECTOR_ROUND  = 33'd511;
  localparam int unsigned SECTOR_SHIFT  = 9;
  localparam logic [31:0] FIRST_CLUSTER = 32'd2;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_SETUP   = 4'd1,
    ST_FIRST   = 4'd2,
    ST_ZERO    = 4'd3,
    ST_RANGE   = 4'd4,
    ST_OVERLAP = 4'd5,
    ST_SUM     = 4'd6,
    ST_MANY    = 4'd7,
    ST_TOTAL   = 4'd8
  } status_e;

  typedef struct packed {
    logic [31:0] data_start_sector;
    logic [31:0] data_cluster_total;
    logic [7:0]  sectors_in_cluster;
    logic [31:0] movie_start_cluster;
    logic [31:0] movie_byte_size;
    logic [31:0] movie_sector_total;
  } cfg_t;

  typedef struct packed {
    status_e          check_status;
    logic             verdict_ready;
    logic [NUM_W-1:0] extent_number;
  } result_t;

endpackage

// ----- sv/delv_ram.sv -----
// ----------------------------------------------------------------------------
// delv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module delv_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/delv_engine.sv -----
// ----------------------------------------------------------------------------
// delv_engine
// Per-extent sequencer: setup and range checks, overlap scan over the kept
// extents in the RAM (one entry per cycle), sticky status and running sum.
// ----------------------------------------------------------------------------
module delv_engine #(
  parameter int unsigned MAX_EXTENTS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  delv_pkg::cfg_t   cfg_i,
  input  logic             req_i,
  input  logic [31:0]      extent_start_i,
  input  logic [31:0]      extent_length_i,
  input  logic             final_extent_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output delv_pkg::result_t res_o
);

  localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned TW = $clog2(MAX_EXTENTS + 1);
  localparam logic [TW-1:0] TALLY_MAX = TW'(MAX_EXTENTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  delv_pkg::status_e sticky_q, sticky_d;
  delv_pkg::status_e st_q, st_d;
  logic [TW-1:0] tally_q, tally_d;
  logic [32:0]   sum_q, sum_d;
  logic [AW-1:0] ptr_q, ptr_d;

  // item payload and precomputed products
  logic [31:0] start_q, len_q;
  logic        fin_q;
  logic [39:0] first_prod_q, area_prod_q;
  logic [32:0] end_q;

  logic [AW-1:0] raddr;
  logic [64:0]   rdata;
  logic          we;
  logic [31:0]   kept_start;
  logic [32:0]   kept_end;

  delv_pkg::status_e setup_st, ext_st, chk_st;
  logic [32:0] expect_start;
  logic [40:0] area_end;
  logic [33:0] sum_ext;
  logic [32:0] round_secs;
  logic        overlap;
  logic        tally_full;
  delv_pkg::status_e fin_sticky;
  logic [32:0] fin_sum;

  assign kept_start = rdata[64:33];
  assign kept_end   = rdata[32:0];
  assign tally_full = (tally_q >= TALLY_MAX);

  delv_ram #(
    .WIDTH(65),
    .DEPTH(MAX_EXTENTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tally_q[AW-1:0]),
    .wdata_i({start_q, end_q}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // scalar checks, evaluated in S_CHECK
  always_comb begin
    expect_start = {1'b0, cfg_i.data_start_sector} + {1'b0, first_prod_q[31:0]};
    round_secs   = ({1'b0, cfg_i.movie_byte_size} + delv_pkg::SECTOR_ROUND)
                   >> delv_pkg::SECTOR_SHIFT;
    area_end     = {9'd0, cfg_i.data_start_sector} + {1'b0, area_prod_q};
    sum_ext      = {1'b0, sum_q} + {2'b00, len_q};

    if (cfg_i.sectors_in_cluster == 8'd0 ||
        cfg_i.movie_start_cluster < delv_pkg::FIRST_CLUSTER) begin
      setup_st = delv_pkg::ST_SETUP;
    end else if (cfg_i.movie_byte_size > delv_pkg::MAX_BYTE_SIZE) begin
      setup_st = delv_pkg::ST_TOTAL;
    end else if ({1'b0, cfg_i.movie_sector_total} != round_secs) begin
      setup_st = delv_pkg::ST_TOTAL;
    end else if (first_prod_q[39:32] != 8'd0) begin
      setup_st = delv_pkg::ST_FIRST;
    end else if (expect_start[32] || expect_start[31:0] != start_q) begin
      setup_st = delv_pkg::ST_FIRST;
    end else begin
      setup_st = delv_pkg::ST_OK;
    end

    if (len_q == 32'd0) begin
      ext_st = delv_pkg::ST_ZERO;
    end else if (start_q < cfg_i.data_start_sector || {8'd0, end_q} > area_end) begin
      ext_st = delv_pkg::ST_RANGE;
    end else if (sum_ext[33:32] != 2'b00) begin
      ext_st = delv_pkg::ST_SUM;
    end else begin
      ext_st = delv_pkg::ST_OK;
    end

    if (tally_q == '0 && setup_st != delv_pkg::ST_OK) begin
      chk_st = setup_st;
    end else begin
      chk_st = ext_st;
    end
  end

  assign overlap = ({1'b0, start_q} < kept_end) && ({1'b0, kept_start} < end_q);

  // commit of the item, evaluated in S_FINISH
  always_comb begin
    fin_sticky = sticky_q;
    fin_sum    = sum_q;
    we         = 1'b0;
    if (state_q == S_FINISH && sticky_q == delv_pkg::ST_OK) begin
      if (tally_full) begin
        fin_sticky = delv_pkg::ST_MANY;
      end else begin
        fin_sticky = st_q;
        if (st_q == delv_pkg::ST_OK) begin
          we      = 1'b1;
          fin_sum = sum_q + {1'b0, len_q};
        end
      end
    end
    if (fin_q && fin_sticky == delv_pkg::ST_OK &&
        fin_sum != {1'b0, cfg_i.movie_sector_total}) begin
      fin_sticky = delv_pkg::ST_TOTAL;
    end
  end

  always_comb begin
    state_d  = state_q;
    sticky_d = sticky_q;
    st_d     = st_q;
    tally_d  = tally_q;
    sum_d    = sum_q;
    ptr_d    = ptr_q;
    raddr    = AW'(ptr_q + AW'(1));
    case (state_q)
      S_IDLE: begin
        if (req_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        st_d  = chk_st;
        ptr_d = '0;
        raddr = '0;
        if (sticky_q != delv_pkg::ST_OK || tally_full || chk_st != delv_pkg::ST_OK ||
            tally_q == '0) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (overlap) begin
          st_d    = delv_pkg::ST_OVERLAP;
          state_d = S_FINISH;
        end else if (ptr_q == AW'(tally_q - TW'(1))) begin
          state_d = S_FINISH;
        end else begin
          ptr_d = AW'(ptr_q + AW'(1));
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
        if (fin_q) begin
          sticky_d = delv_pkg::ST_OK;
          sum_d    = '0;
          tally_d  = '0;
        end else begin
          sticky_d = fin_sticky;
          sum_d    = fin_sum;
          tally_d  = tally_full ? tally_q : TW'(tally_q + TW'(1));
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sticky_q <= delv_pkg::ST_OK;
      st_q     <= delv_pkg::ST_OK;
      tally_q  <= '0;
      sum_q    <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      sticky_q <= sticky_d;
      st_q     <= st_d;
      tally_q  <= tally_d;
      sum_q    <= sum_d;
      ptr_q    <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i) begin
      start_q <= extent_start_i;
      len_q   <= extent_length_i;
      fin_q   <= final_extent_i;
    end
    if (state_q == S_PREP) begin
      first_prod_q <= {8'd0, cfg_i.movie_start_cluster - delv_pkg::FIRST_CLUSTER}
                      * {32'd0, cfg_i.sectors_in_cluster};
      area_prod_q  <= {8'd0, cfg_i.data_cluster_total} * {32'd0, cfg_i.sectors_in_cluster};
      end_q        <= {1'b0, start_q} + {1'b0, len_q};
    end
  end

  assign busy_o                = (state_q != S_IDLE);
  assign res_valid_o           = (state_q == S_FINISH);
  assign res_o.check_status    = fin_sticky;
  assign res_o.verdict_ready   = fin_q;
  assign res_o.extent_number   = delv_pkg::NUM_W'(tally_q);

endmodule

// ----- sv/disk_extent_list_validator_core.sv -----
// ----------------------------------------------------------------------------
// disk_extent_list_validator_core
// Checks a movie's list of disk extents against the volume setup.
// ----------------------------------------------------------------------------
// Usage:
//   Program the six volume/movie registers through the cfg channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) while the block is idle;
//   cfg_ready_o is always high. Send extents one request at a time: a request
//   is taken at an edge with start high and busy low.
//   Each request yields exactly one result on check_status_o, verdict_ready_o
//   and extent_number_o, marked by done_o for a single cycle; the receiver
//   cannot stall it. The status is sticky: the first error of a list is
//   reported until the request marked final, which closes the list.
// Sequence:
//   After the accepting edge the engine steps through S_PREP, S_CHECK, the
//   overlap scan in S_SCAN (one kept extent per cycle from the extent RAM,
//   skipped when nothing is kept or an error is found, ended by an overlap)
//   and S_FINISH, from which done_o is registered; busy falls after S_FINISH.
// Reset:
//   Registers return to their defaults and the list state clears; the extent
//   RAM needs no clearing since only entries of the current list are read.
// ----------------------------------------------------------------------------
module disk_extent_list_validator_core #(
  parameter int unsigned MAX_EXTENTS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [delv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    extent_start_i,
  input  logic [31:0]                    extent_length_i,
  input  logic                           final_extent_i,
  output logic                           done_o,
  output logic [3:0]                     check_status_o,
  output logic                           verdict_ready_o,
  output logic [delv_pkg::NUM_W-1:0]     extent_number_o
);

  delv_pkg::cfg_t    cfg_q;
  delv_pkg::result_t res, res_q;
  logic              res_valid;
  logic              done_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_start_sector   <= 32'd0;
      cfg_q.data_cluster_total  <= 32'd0;
      cfg_q.sectors_in_cluster  <= 8'd1;
      cfg_q.movie_start_cluster <= 32'd2;
      cfg_q.movie_byte_size     <= 32'd0;
      cfg_q.movie_sector_total  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        delv_pkg::CFG_DATA_START:   cfg_q.data_start_sector   <= cfg_data_i;
        delv_pkg::CFG_CLUSTER_TOT:  cfg_q.data_cluster_total  <= cfg_data_i;
        delv_pkg::CFG_SEC_PER_CLUS: cfg_q.sectors_in_cluster  <= cfg_data_i[7:0];
        delv_pkg::CFG_MOVIE_CLUS:   cfg_q.movie_start_cluster <= cfg_data_i;
        delv_pkg::CFG_MOVIE_BYTES:  cfg_q.movie_byte_size     <= cfg_data_i;
        delv_pkg::CFG_MOVIE_SECS:   cfg_q.movie_sector_total  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  delv_engine #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .req_i          (start),
    .extent_start_i (extent_start_i),
    .extent_length_i(extent_length_i),
    .final_extent_i (final_extent_i),
    .busy_o         (busy),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign done_o          = done_q;
  assign check_status_o  = res_q.check_status;
  assign verdict_ready_o = res_q.verdict_ready;
  assign extent_number_o = res_q.extent_number;

endmodule

// ----- sv/delv_checker.sv -----
// ----------------------------------------------------------------------------
// delv_checker
// Port-level checks of the extent list validator, bound to the top level.
// ----------------------------------------------------------------------------
module delv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [3:0] check_status_o
);

  // an accepted request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only appears once the work of its request is over
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe without a finished request");

  // no result right after a request is taken
  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o)
    else $error("result strobe too early");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> check_status_o <= 4'd8)
    else $error("status code out of range");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind disk_extent_list_validator_core delv_checker u_delv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_o   (cfg_ready_o),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .check_status_o(check_status_o)
);
